### hw/rtl/cpu8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpu8_pkg;

    // Status bit positions: N V 1 B D I Z C
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Reset values of the programmer-visible registers
    localparam logic [7:0] ACC_RESET    = 8'h00;
    localparam logic [7:0] INDEX_RESET  = 8'h00;
    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    // Bits forced on a status push, and bits taken from a status pop
    localparam logic [7:0] FIXED_BITS  = 8'h30;
    localparam logic [7:0] POPPED_BITS = 8'hCF;

    // Operation codes, alphabetical
    typedef enum logic [5:0] {
        OP_ADC, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI, OP_BNE, OP_BPL,
        OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_CMP, OP_CPX, OP_CPY, OP_DCP,
        OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC, OP_INX, OP_INY, OP_ISB, OP_JMP, OP_LAX,
        OP_LDA, OP_LDX, OP_LDY, OP_LSR, OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA, OP_PLP,
        OP_RLA, OP_ROL, OP_ROR, OP_RRA, OP_SAX, OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_SLO,
        OP_SRE, OP_STA, OP_STX, OP_STY, OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
    } t_op;

    // Architectural register file
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] status;
    } t_regs;

    // Side effects of one instruction
    typedef struct packed {
        logic [7:0]  wdata;
        logic        wmem;
        logic        push;
        logic [7:0]  saddr;
        logic        branch;
        logic [15:0] btarget;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/cpu_8bit_execute_unit.sv
// An accepted item moves from the input register to the result register and is offered from there.
// Throughput: 1 item per cycle while m_axis_tready is high; the input and result registers
// each hold one item, so input is taken into an empty input register while a result waits to be taken.
// Reset (i_rst_n, synchronous, active low): A, X, Y = 0, SP = 0xFD,
// status = 0x24, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module cpu_8bit_execute_unit
    import cpu8_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // command[5:0], operand[13:6], target_address[29:14]
    input  wire logic [0:0]  s_axis_tuser,  // to_accumulator[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // write_data[7:0], stack_address[15:8],
                                            // branch_target[31:16], status_out[39:32],
                                            // accumulator_out[47:40]
    output logic [2:0]       m_axis_tuser   // write_memory[0], push_stack[1], branch_taken[2]
);

    logic        r_in_valid;
    t_op         r_in_cmd;
    logic [7:0]  r_in_operand;
    logic [15:0] r_in_target;
    logic        r_in_to_acc;
    logic        r_out_valid;
    t_result     r_out_res;
    t_regs       r_out_regs;
    t_regs       r_regs;
    t_regs       n_regs;
    t_result     n_res;
    logic        in_take;
    logic        advance;

    // Pipeline handshake
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
        end
        if (in_take) begin
            r_in_cmd     <= t_op'(s_axis_tdata[5:0]);
            r_in_operand <= s_axis_tdata[13:6];
            r_in_target  <= s_axis_tdata[29:14];
            r_in_to_acc  <= s_axis_tuser[0];
        end
    end

    cpu8_alu u_alu (
        .i_cmd     (r_in_cmd),
        .i_operand (r_in_operand),
        .i_target  (r_in_target),
        .i_to_acc  (r_in_to_acc),
        .i_regs    (r_regs),
        .o_regs    (n_regs),
        .o_res     (n_res)
    );

    // Architectural registers, updated as an item moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.acc    <= ACC_RESET;
            r_regs.x      <= INDEX_RESET;
            r_regs.y      <= INDEX_RESET;
            r_regs.sp     <= SP_RESET;
            r_regs.status <= STATUS_RESET;
        end else if (advance) begin
            r_regs <= n_regs;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !m_axis_tready);
        end
        if (advance) begin
            r_out_res  <= n_res;
            r_out_regs <= n_regs;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_regs.acc, r_out_regs.status, r_out_res.btarget,
                            r_out_res.saddr, r_out_res.wdata};
    assign m_axis_tuser  = {r_out_res.branch, r_out_res.push, r_out_res.wmem};

    // Bit 5 always set, bit 4 always clear in the held status
    a_status_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.status[5:4] == 2'b10)
        else $error("status bits 5:4 corrupted");

    // A result never both stores and pushes
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("memory write and stack push in one result");

    // No branch means a zero target
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata[31:16] == 16'd0))
        else $error("branch target set without a branch");

    // A push post-decrements the stack pointer
    a_push_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_cmd == OP_PHA || r_in_cmd == OP_PHP))
        |=> (r_regs.sp == $past(r_regs.sp) - 8'd1))
        else $error("stack pointer not decremented on push");

endmodule

`default_nettype wire

### hw/rtl/cpu8_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module cpu8_alu
    import cpu8_pkg::*;
(
    input  wire t_op         i_cmd,
    input  wire logic [7:0]  i_operand,
    input  wire logic [15:0] i_target,
    input  wire logic        i_to_acc,
    input  wire t_regs       i_regs,
    output t_regs            o_regs,
    output t_result          o_res
);

    // Rebuild status with new N, V, Z, C; I, D and bits 4/5 kept
    function automatic logic [7:0] f_flags(input logic [7:0] p, input logic n,
                                           input logic v, input logic z, input logic c);
        f_flags = {n, v, p[5:2], z, c};
    endfunction

    logic       c_old;
    logic       plain_shift;
    logic       sh_left;
    logic       sh_rot;
    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic       sh_c;
    logic [7:0] inc_m;
    logic [7:0] dec_m;
    logic [7:0] add_m;
    logic       add_cin;
    logic [8:0] sum;
    logic       ovf;
    logic [7:0] cmp_reg;
    logic [7:0] cmp_m;
    logic [8:0] diff;
    logic [7:0] slo_a;
    logic [7:0] rla_a;
    logic [7:0] sre_a;
    logic [7:0] nx;
    logic [7:0] ny;
    logic [7:0] sp_inc;

    assign c_old  = i_regs.status[FLAG_C];
    assign inc_m  = i_operand + 8'd1;
    assign dec_m  = i_operand - 8'd1;
    assign sp_inc = i_regs.sp + 8'd1;

    // Shifter: accumulator form only for the plain shift ops
    assign plain_shift = (i_cmd == OP_ASL) || (i_cmd == OP_LSR) ||
                         (i_cmd == OP_ROL) || (i_cmd == OP_ROR);
    assign sh_left = (i_cmd == OP_ASL) || (i_cmd == OP_ROL) ||
                     (i_cmd == OP_SLO) || (i_cmd == OP_RLA);
    assign sh_rot  = (i_cmd == OP_ROL) || (i_cmd == OP_ROR) ||
                     (i_cmd == OP_RLA) || (i_cmd == OP_RRA);
    assign sh_src  = (plain_shift && i_to_acc) ? i_regs.acc : i_operand;
    assign sh_res  = sh_left ? {sh_src[6:0], sh_rot & c_old} : {sh_rot & c_old, sh_src[7:1]};
    assign sh_c    = sh_left ? sh_src[7] : sh_src[0];

    assign slo_a = i_regs.acc | sh_res;
    assign rla_a = i_regs.acc & sh_res;
    assign sre_a = i_regs.acc ^ sh_res;

    // Adder shared by ADC, SBC, ISB and RRA
    always_comb begin
        unique case (i_cmd)
            OP_SBC:  add_m = ~i_operand;
            OP_ISB:  add_m = ~inc_m;
            OP_RRA:  add_m = sh_res;
            default: add_m = i_operand;
        endcase
    end
    assign add_cin = (i_cmd == OP_RRA) ? sh_c : c_old;
    assign sum     = {1'b0, i_regs.acc} + {1'b0, add_m} + {8'd0, add_cin};
    assign ovf     = ~(i_regs.acc[7] ^ add_m[7]) & (i_regs.acc[7] ^ sum[7]);

    // Comparator shared by CMP, CPX, CPY and DCP
    always_comb begin
        unique case (i_cmd)
            OP_CPX:  cmp_reg = i_regs.x;
            OP_CPY:  cmp_reg = i_regs.y;
            default: cmp_reg = i_regs.acc;
        endcase
    end
    assign cmp_m = (i_cmd == OP_DCP) ? dec_m : i_operand;
    assign diff  = {1'b0, cmp_reg} - {1'b0, cmp_m};

    // Per-operation register and flag update
    always_comb begin
        o_regs = i_regs;
        o_res  = '0;
        nx     = i_regs.x;
        ny     = i_regs.y;
        unique case (i_cmd)
            OP_ADC, OP_SBC: begin
                o_regs.acc    = sum[7:0];
                o_regs.status = f_flags(i_regs.status, sum[7], ovf, sum[7:0] == 8'd0, sum[8]);
            end
            OP_AND: begin
                o_regs.acc    = i_regs.acc & i_operand;
                o_regs.status = f_flags(i_regs.status, o_regs.acc[7], i_regs.status[FLAG_V],
                                        o_regs.acc == 8'd0, c_old);
            end
            OP_EOR: begin
                o_regs.acc    = i_regs.acc ^ i_operand;
                o_regs.status = f_flags(i_regs.status, o_regs.acc[7], i_regs.status[FLAG_V],
                                        o_regs.acc == 8'd0, c_old);
            end
            OP_ORA: begin
                o_regs.acc    = i_regs.acc | i_operand;
                o_regs.status = f_flags(i_regs.status, o_regs.acc[7], i_regs.status[FLAG_V],
                                        o_regs.acc == 8'd0, c_old);
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                o_regs.status = f_flags(i_regs.status, sh_res[7], i_regs.status[FLAG_V],
                                        sh_res == 8'd0, sh_c);
                if (i_to_acc) begin
                    o_regs.acc = sh_res;
                end else begin
                    o_res.wdata = sh_res;
                    o_res.wmem  = 1'b1;
                end
            end
            OP_BCC: o_res.branch = ~i_regs.status[FLAG_C];
            OP_BCS: o_res.branch = i_regs.status[FLAG_C];
            OP_BEQ: o_res.branch = i_regs.status[FLAG_Z];
            OP_BNE: o_res.branch = ~i_regs.status[FLAG_Z];
            OP_BMI: o_res.branch = i_regs.status[FLAG_N];
            OP_BPL: o_res.branch = ~i_regs.status[FLAG_N];
            OP_BVS: o_res.branch = i_regs.status[FLAG_V];
            OP_BVC: o_res.branch = ~i_regs.status[FLAG_V];
            OP_JMP: o_res.branch = 1'b1;
            OP_BIT: begin
                o_regs.status = f_flags(i_regs.status, i_operand[7], i_operand[6],
                                        (i_regs.acc & i_operand) == 8'd0, c_old);
            end
            OP_CLC: o_regs.status[FLAG_C] = 1'b0;
            OP_CLD: o_regs.status[FLAG_D] = 1'b0;
            OP_CLI: o_regs.status[FLAG_I] = 1'b0;
            OP_CLV: o_regs.status[FLAG_V] = 1'b0;
            OP_SEC: o_regs.status[FLAG_C] = 1'b1;
            OP_SED: o_regs.status[FLAG_D] = 1'b1;
            OP_SEI: o_regs.status[FLAG_I] = 1'b1;
            OP_CMP, OP_CPX, OP_CPY: begin
                o_regs.status = f_flags(i_regs.status, diff[7], i_regs.status[FLAG_V],
                                        diff[7:0] == 8'd0, ~diff[8]);
            end
            OP_DCP: begin
                o_res.wdata   = dec_m;
                o_res.wmem    = 1'b1;
                o_regs.status = f_flags(i_regs.status, diff[7], i_regs.status[FLAG_V],
                                        diff[7:0] == 8'd0, ~diff[8]);
            end
            OP_DEC: begin
                o_res.wdata   = dec_m;
                o_res.wmem    = 1'b1;
                o_regs.status = f_flags(i_regs.status, dec_m[7], i_regs.status[FLAG_V],
                                        dec_m == 8'd0, c_old);
            end
            OP_INC: begin
                o_res.wdata   = inc_m;
                o_res.wmem    = 1'b1;
                o_regs.status = f_flags(i_regs.status, inc_m[7], i_regs.status[FLAG_V],
                                        inc_m == 8'd0, c_old);
            end
            OP_ISB: begin
                o_res.wdata   = inc_m;
                o_res.wmem    = 1'b1;
                o_regs.acc    = sum[7:0];
                o_regs.status = f_flags(i_regs.status, sum[7], ovf, sum[7:0] == 8'd0, sum[8]);
            end
            OP_RRA: begin
                o_res.wdata   = sh_res;
                o_res.wmem    = 1'b1;
                o_regs.acc    = sum[7:0];
                o_regs.status = f_flags(i_regs.status, sum[7], ovf, sum[7:0] == 8'd0, sum[8]);
            end
            OP_SLO: begin
                o_res.wdata   = sh_res;
                o_res.wmem    = 1'b1;
                o_regs.acc    = slo_a;
                o_regs.status = f_flags(i_regs.status, slo_a[7], i_regs.status[FLAG_V],
                                        slo_a == 8'd0, sh_c);
            end
            OP_RLA: begin
                o_res.wdata   = sh_res;
                o_res.wmem    = 1'b1;
                o_regs.acc    = rla_a;
                o_regs.status = f_flags(i_regs.status, rla_a[7], i_regs.status[FLAG_V],
                                        rla_a == 8'd0, sh_c);
            end
            OP_SRE: begin
                o_res.wdata   = sh_res;
                o_res.wmem    = 1'b1;
                o_regs.acc    = sre_a;
                o_regs.status = f_flags(i_regs.status, sre_a[7], i_regs.status[FLAG_V],
                                        sre_a == 8'd0, sh_c);
            end
            OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX: begin
                unique case (i_cmd)
                    OP_DEX:  nx = i_regs.x - 8'd1;
                    OP_INX:  nx = i_regs.x + 8'd1;
                    OP_LDX:  nx = i_operand;
                    OP_TAX:  nx = i_regs.acc;
                    default: nx = i_regs.sp;
                endcase
                o_regs.x      = nx;
                o_regs.status = f_flags(i_regs.status, nx[7], i_regs.status[FLAG_V],
                                        nx == 8'd0, c_old);
            end
            OP_DEY, OP_INY, OP_LDY, OP_TAY: begin
                unique case (i_cmd)
                    OP_DEY:  ny = i_regs.y - 8'd1;
                    OP_INY:  ny = i_regs.y + 8'd1;
                    OP_LDY:  ny = i_operand;
                    default: ny = i_regs.acc;
                endcase
                o_regs.y      = ny;
                o_regs.status = f_flags(i_regs.status, ny[7], i_regs.status[FLAG_V],
                                        ny == 8'd0, c_old);
            end
            OP_LAX, OP_LDA: begin
                o_regs.acc = i_operand;
                if (i_cmd == OP_LAX) begin
                    o_regs.x = i_operand;
                end
                o_regs.status = f_flags(i_regs.status, i_operand[7], i_regs.status[FLAG_V],
                                        i_operand == 8'd0, c_old);
            end
            OP_TXA, OP_TYA: begin
                o_regs.acc    = (i_cmd == OP_TXA) ? i_regs.x : i_regs.y;
                o_regs.status = f_flags(i_regs.status, o_regs.acc[7], i_regs.status[FLAG_V],
                                        o_regs.acc == 8'd0, c_old);
            end
            OP_TXS: o_regs.sp = i_regs.x;
            // Push: write at SP, then post-decrement
            OP_PHA, OP_PHP: begin
                o_res.wdata = (i_cmd == OP_PHA) ? i_regs.acc : (i_regs.status | FIXED_BITS);
                o_res.push  = 1'b1;
                o_res.saddr = i_regs.sp;
                o_regs.sp   = i_regs.sp - 8'd1;
            end
            // Pop: pre-increment, popped byte arrives as the operand
            OP_PLA: begin
                o_regs.sp     = sp_inc;
                o_res.saddr   = sp_inc;
                o_regs.acc    = i_operand;
                o_regs.status = f_flags(i_regs.status, i_operand[7], i_regs.status[FLAG_V],
                                        i_operand == 8'd0, c_old);
            end
            OP_PLP: begin
                o_regs.sp     = sp_inc;
                o_res.saddr   = sp_inc;
                o_regs.status = (i_regs.status & FIXED_BITS) | (i_operand & POPPED_BITS);
            end
            OP_SAX, OP_STA, OP_STX, OP_STY: begin
                unique case (i_cmd)
                    OP_SAX:  o_res.wdata = i_regs.acc & i_regs.x;
                    OP_STA:  o_res.wdata = i_regs.acc;
                    OP_STX:  o_res.wdata = i_regs.x;
                    default: o_res.wdata = i_regs.y;
                endcase
                o_res.wmem = 1'b1;
            end
            // NOP and the unused codes leave everything as it is
            default: o_regs = i_regs;
        endcase
        o_res.btarget = o_res.branch ? i_target : 16'd0;
    end

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cpu8_pkg::*;

    // Command codes above TYA decode to nothing
    localparam logic [5:0] CMD_SPARE_LAST = 6'd63;
    localparam int         RANDOM_ITEMS   = 1700;
    localparam int         STALL_LIMIT    = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         MAX_REPORTS    = 10;

    // One instruction as it enters the execute stage
    typedef struct packed {
        logic [5:0]  cmd;
        logic [7:0]  operand;
        logic [15:0] target;
        logic        to_acc;
    } t_instr;

    // Everything one instruction leaves behind
    typedef struct packed {
        t_result    side;
        logic [7:0] status;
        logic [7:0] acc;
    } t_exec_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // command[5:0], operand[13:6], target_address[29:14]
    logic [0:0]  s_axis_tuser = '0;   // to_accumulator[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // write_data[7:0], stack_address[15:8],
                                      // branch_target[31:16], status_out[39:32],
                                      // accumulator_out[47:40]
    logic [2:0]  m_axis_tuser;        // write_memory[0], push_stack[1], branch_taken[2]

    t_instr    program_queue[$];
    t_exec_out expected_results[$];

    // Architectural state as the testbench sees it
    logic [7:0] arch_acc    = ACC_RESET;
    logic [7:0] arch_x      = INDEX_RESET;
    logic [7:0] arch_y      = INDEX_RESET;
    logic [7:0] arch_sp     = SP_RESET;
    logic [7:0] arch_status = STATUS_RESET;

    logic instr_taken  = 1'b0;
    int   instrs_taken = 0;
    int   results_seen = 0;
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    logic steady_phase;

    cpu_8bit_execute_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // No back-pressure or gaps on either side for a stretch in the middle
    assign steady_phase = (instrs_taken >= 700) && (instrs_taken < 1000);

    // Flag helpers
    function automatic logic [7:0] set_nz(logic [7:0] v);
        arch_status[FLAG_Z] = (v == 8'h00);
        arch_status[FLAG_N] = v[7];
        return v;
    endfunction

    function automatic void add_to_acc(logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, arch_acc} + {1'b0, m} + {8'h00, arch_status[FLAG_C]};
        arch_status[FLAG_C] = sum[8];
        arch_status[FLAG_V] = ~(arch_acc[7] ^ m[7]) & (arch_acc[7] ^ sum[7]);
        arch_acc = set_nz(sum[7:0]);
    endfunction

    function automatic void compare_reg(logic [7:0] reg_v, logic [7:0] m);
        arch_status[FLAG_C] = (reg_v >= m);
        void'(set_nz(reg_v - m));
    endfunction

    // Rotates bring the old carry in at the vacated end
    function automatic logic [7:0] shift_byte(logic [7:0] v, logic right, logic rotate);
        logic       cin;
        logic [7:0] r;
        cin = rotate ? arch_status[FLAG_C] : 1'b0;
        if (!right) begin
            arch_status[FLAG_C] = v[7];
            r = {v[6:0], cin};
        end else begin
            arch_status[FLAG_C] = v[0];
            r = {cin, v[7:1]};
        end
        return set_nz(r);
    endfunction

    // Executes one instruction on the architectural state
    function automatic t_exec_out execute_instr(t_instr it);
        t_exec_out  r;
        logic [7:0] m;
        r = '0;
        m = it.operand;
        case (it.cmd)
            OP_ADC: add_to_acc(m);
            OP_SBC: add_to_acc(~m);
            OP_AND: arch_acc = set_nz(arch_acc & m);
            OP_EOR: arch_acc = set_nz(arch_acc ^ m);
            OP_ORA: arch_acc = set_nz(arch_acc | m);
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                if (it.to_acc) begin
                    arch_acc = shift_byte(arch_acc, it.cmd == OP_LSR || it.cmd == OP_ROR,
                                          it.cmd == OP_ROL || it.cmd == OP_ROR);
                end else begin
                    r.side.wdata = shift_byte(m, it.cmd == OP_LSR || it.cmd == OP_ROR,
                                              it.cmd == OP_ROL || it.cmd == OP_ROR);
                    r.side.wmem = 1'b1;
                end
            end
            OP_BCC: r.side.branch = !arch_status[FLAG_C];
            OP_BCS: r.side.branch = arch_status[FLAG_C];
            OP_BEQ: r.side.branch = arch_status[FLAG_Z];
            OP_BNE: r.side.branch = !arch_status[FLAG_Z];
            OP_BMI: r.side.branch = arch_status[FLAG_N];
            OP_BPL: r.side.branch = !arch_status[FLAG_N];
            OP_BVS: r.side.branch = arch_status[FLAG_V];
            OP_BVC: r.side.branch = !arch_status[FLAG_V];
            OP_JMP: r.side.branch = 1'b1;
            OP_BIT: begin
                arch_status[FLAG_Z] = ((arch_acc & m) == 8'h00);
                arch_status[FLAG_N] = m[7];
                arch_status[FLAG_V] = m[6];
            end
            OP_CLC: arch_status[FLAG_C] = 1'b0;
            OP_CLD: arch_status[FLAG_D] = 1'b0;
            OP_CLI: arch_status[FLAG_I] = 1'b0;
            OP_CLV: arch_status[FLAG_V] = 1'b0;
            OP_SEC: arch_status[FLAG_C] = 1'b1;
            OP_SED: arch_status[FLAG_D] = 1'b1;
            OP_SEI: arch_status[FLAG_I] = 1'b1;
            OP_CMP: compare_reg(arch_acc, m);
            OP_CPX: compare_reg(arch_x, m);
            OP_CPY: compare_reg(arch_y, m);
            OP_DEC: begin
                r.side.wdata = set_nz(m - 8'd1);
                r.side.wmem  = 1'b1;
            end
            OP_INC: begin
                r.side.wdata = set_nz(m + 8'd1);
                r.side.wmem  = 1'b1;
            end
            // Combined ops always write the modified byte back to memory
            OP_DCP: begin
                r.side.wdata = m - 8'd1;
                r.side.wmem  = 1'b1;
                compare_reg(arch_acc, r.side.wdata);
            end
            OP_ISB: begin
                r.side.wdata = m + 8'd1;
                r.side.wmem  = 1'b1;
                add_to_acc(~r.side.wdata);
            end
            OP_SLO: begin
                r.side.wdata = shift_byte(m, 1'b0, 1'b0);
                r.side.wmem  = 1'b1;
                arch_acc = set_nz(arch_acc | r.side.wdata);
            end
            OP_SRE: begin
                r.side.wdata = shift_byte(m, 1'b1, 1'b0);
                r.side.wmem  = 1'b1;
                arch_acc = set_nz(arch_acc ^ r.side.wdata);
            end
            OP_RLA: begin
                r.side.wdata = shift_byte(m, 1'b0, 1'b1);
                r.side.wmem  = 1'b1;
                arch_acc = set_nz(arch_acc & r.side.wdata);
            end
            OP_RRA: begin
                r.side.wdata = shift_byte(m, 1'b1, 1'b1);
                r.side.wmem  = 1'b1;
                add_to_acc(r.side.wdata);
            end
            OP_DEX: arch_x = set_nz(arch_x - 8'd1);
            OP_DEY: arch_y = set_nz(arch_y - 8'd1);
            OP_INX: arch_x = set_nz(arch_x + 8'd1);
            OP_INY: arch_y = set_nz(arch_y + 8'd1);
            OP_LAX: begin
                arch_acc = set_nz(m);
                arch_x   = m;
            end
            OP_LDA: arch_acc = set_nz(m);
            OP_LDX: arch_x = set_nz(m);
            OP_LDY: arch_y = set_nz(m);
            // Push: store at SP, then post-decrement
            OP_PHA, OP_PHP: begin
                r.side.wdata = (it.cmd == OP_PHA) ? arch_acc : (arch_status | FIXED_BITS);
                r.side.push  = 1'b1;
                r.side.saddr = arch_sp;
                arch_sp = arch_sp - 8'd1;
            end
            // Pop: pre-increment, the popped byte comes in as the operand
            OP_PLA, OP_PLP: begin
                arch_sp = arch_sp + 8'd1;
                r.side.saddr = arch_sp;
                if (it.cmd == OP_PLA)
                    arch_acc = set_nz(m);
                else
                    arch_status = (arch_status & FIXED_BITS) | (m & POPPED_BITS);
            end
            OP_SAX: begin
                r.side.wdata = arch_acc & arch_x;
                r.side.wmem  = 1'b1;
            end
            OP_STA: begin
                r.side.wdata = arch_acc;
                r.side.wmem  = 1'b1;
            end
            OP_STX: begin
                r.side.wdata = arch_x;
                r.side.wmem  = 1'b1;
            end
            OP_STY: begin
                r.side.wdata = arch_y;
                r.side.wmem  = 1'b1;
            end
            OP_TAX: arch_x = set_nz(arch_acc);
            OP_TAY: arch_y = set_nz(arch_acc);
            OP_TSX: arch_x = set_nz(arch_sp);
            OP_TXA: arch_acc = set_nz(arch_x);
            OP_TXS: arch_sp = arch_x;
            OP_TYA: arch_acc = set_nz(arch_y);
            default: ;
        endcase
        if (r.side.branch)
            r.side.btarget = it.target;
        r.status = arch_status;
        r.acc    = arch_acc;
        return r;
    endfunction

    task automatic check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, field, want_v, got_v);
        end
    endtask

    task automatic add_instr(logic [5:0] cmd, logic [7:0] opd, logic [15:0] tgt, logic acc);
        t_instr it;
        it.cmd     = cmd;
        it.operand = opd;
        it.target  = tgt;
        it.to_acc  = acc;
        program_queue.push_back(it);
    endtask

    // Operands lean towards the byte boundaries that flip flags
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Input driver: changes only at the falling edge
    always @(negedge i_clk) begin
        t_instr queued;
        if (i_rst_n) begin
            if (!s_axis_tvalid || instr_taken) begin
                if (program_queue.size() != 0 && (steady_phase || $urandom_range(99) >= 20)) begin
                    queued = program_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, queued.target, queued.operand, queued.cmd};
                    s_axis_tuser  <= queued.to_acc;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= steady_phase || ($urandom_range(99) >= 20);
        end
    end

    // Monitor: predicts on input handshakes, checks on output handshakes
    always @(posedge i_clk) begin
        t_exec_out got;
        t_exec_out want;
        t_instr    seen;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.side.wdata   = m_axis_tdata[7:0];
                got.side.saddr   = m_axis_tdata[15:8];
                got.side.btarget = m_axis_tdata[31:16];
                got.status       = m_axis_tdata[39:32];
                got.acc          = m_axis_tdata[47:40];
                got.side.wmem    = m_axis_tuser[0];
                got.side.push    = m_axis_tuser[1];
                got.side.branch  = m_axis_tuser[2];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: item with nothing expected, data 0x%0h user 0x%0h",
                                 results_seen, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = expected_results.pop_front();
                    check_field("write_data", 16'(want.side.wdata), 16'(got.side.wdata));
                    check_field("write_memory", 16'(want.side.wmem), 16'(got.side.wmem));
                    check_field("push_stack", 16'(want.side.push), 16'(got.side.push));
                    check_field("stack_address", 16'(want.side.saddr), 16'(got.side.saddr));
                    check_field("branch_taken", 16'(want.side.branch), 16'(got.side.branch));
                    check_field("branch_target", want.side.btarget, got.side.btarget);
                    check_field("status_out", 16'(want.status), 16'(got.status));
                    check_field("accumulator_out", 16'(want.acc), 16'(got.acc));
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.cmd     = s_axis_tdata[5:0];
                seen.operand = s_axis_tdata[13:6];
                seen.target  = s_axis_tdata[29:14];
                seen.to_acc  = s_axis_tuser[0];
                expected_results.push_back(execute_instr(seen));
                instrs_taken++;
            end
        end
        instr_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[cpu_8bit_execute_unit] ERROR");
            $finish;
        end
    end

    initial begin
        // Flags, overflow and binary arithmetic in decimal mode
        add_instr(OP_LDA, 8'h00, 16'h0000, 1'b0);
        add_instr(OP_LDA, 8'h80, 16'h0000, 1'b0);
        add_instr(OP_LDA, 8'h7F, 16'h0000, 1'b0);
        add_instr(OP_ADC, 8'h01, 16'h0000, 1'b0);
        add_instr(OP_ADC, 8'hFF, 16'h0000, 1'b0);
        add_instr(OP_SED, 8'h00, 16'h0000, 1'b0);
        add_instr(OP_SBC, 8'h00, 16'h0000, 1'b0);
        add_instr(OP_CLD, 8'h00, 16'h0000, 1'b0);
        // Status push/pop keeps bits 4 and 5
        add_instr(OP_PHP, 8'h00, 16'h0000, 1'b0);
        add_instr(OP_PLP, 8'hFF, 16'h0000, 1'b0);
        add_instr(OP_PLP, 8'h00, 16'h0000, 1'b0);
        // Stack pointer wrapping both ways
        add_instr(OP_LDX, 8'hFF, 16'h0000, 1'b0);
        add_instr(OP_TXS, 8'h00, 16'h0000, 1'b0);
        add_instr(OP_PLA, 8'h80, 16'h0000, 1'b0);
        add_instr(OP_LDX, 8'h00, 16'h0000, 1'b0);
        add_instr(OP_TXS, 8'h00, 16'h0000, 1'b0);
        add_instr(OP_PHA, 8'h00, 16'h0000, 1'b0);
        // Shifts on A and memory; combined ops ignore the accumulator flag
        add_instr(OP_ASL, 8'h00, 16'h0000, 1'b1);
        add_instr(OP_ROR, 8'h01, 16'hFFFF, 1'b0);
        add_instr(OP_SLO, 8'h80, 16'h1234, 1'b1);
        add_instr(OP_RRA, 8'hFF, 16'hFFFF, 1'b1);
        add_instr(OP_JMP, 8'hFF, 16'hFFFF, 1'b0);
        add_instr(OP_BEQ, 8'h00, 16'h0000, 1'b0);
        add_instr(OP_STA, 8'h00, 16'hFFFF, 1'b0);
        add_instr(CMD_SPARE_LAST, 8'hFF, 16'hFFFF, 1'b1);
        add_instr(OP_BIT, 8'hFF, 16'h0000, 1'b0);
        // Every command code once, then random instructions
        for (int c = 0; c <= CMD_SPARE_LAST; c++)
            add_instr(c[5:0], pick_operand(), 16'($urandom_range(65535)),
                      1'($urandom_range(1)));
        for (int n = 0; n < RANDOM_ITEMS - 64; n++)
            add_instr(6'($urandom_range(63)), pick_operand(), 16'($urandom_range(65535)),
                      1'($urandom_range(1)));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (program_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("[cpu_8bit_execute_unit] OK");
        else
            $display("[cpu_8bit_execute_unit] ERROR");
        $finish;
    end

endmodule

### cpu_8bit_execute_unit.f
hw/rtl/cpu8_pkg.sv
hw/rtl/cpu8_alu.sv
hw/rtl/cpu_8bit_execute_unit.sv
tb/testbench.sv
